/* hw/rtl/cartesian_to_polar_quadrant_defines.svh */
// Assertion macros for the cartesian_to_polar_quadrant block.
// Included by the top level; needs no other file.
`ifndef CARTESIAN_TO_POLAR_QUADRANT_DEFINES_SVH
`define CARTESIAN_TO_POLAR_QUADRANT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CTP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition in one cycle implies a property in the next cycle.
`define CTP_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/ctp_pkg.sv */
// Shared constants, types and tables of the cartesian to polar converter.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int ROTATION_STEPS = 16;
  localparam int GUARD_BITS     = 16;
  localparam int DEG_FRAC       = 16;
  localparam int TAB_LEN        = 32;

  // One pipeline step serves one rotation and one root digit.
  localparam int NSTG = (ROTATION_STEPS > COORD_BITS) ? ROTATION_STEPS : COORD_BITS;

  localparam int SQW = 2 * COORD_BITS;               // sum of squares
  localparam int RMW = COORD_BITS + 2;               // root remainder
  localparam int CW  = COORD_BITS + GUARD_BITS + 3;  // rotation datapath, signed
  localparam int ZW  = DEG_FRAC + 9;                 // angle accumulator, signed
  localparam int TW  = DEG_FRAC + 7;                 // clamped angle, 0 .. 90 deg
  localparam int FW  = DEG_FRAC + 9;                 // folded angle, 0 .. 360 deg
  localparam int ATAN_W = ZW - 1;

  localparam int RADIUS_W = 16;
  localparam int ANGLE_W  = 17;
  localparam int RND_W    = COORD_BITS + 1;
  localparam int RND_EXT_W = (RND_W > RADIUS_W) ? RND_W : RADIUS_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  localparam logic [FW-1:0] DEG_90     = FW'(90 * (2 ** DEG_FRAC));
  localparam logic [FW-1:0] DEG_180    = FW'(180 * (2 ** DEG_FRAC));
  localparam logic [FW-1:0] DEG_360    = FW'(360 * (2 ** DEG_FRAC));
  localparam logic [FW-1:0] ROUND_BIAS = FW'(2 ** (DEG_FRAC - 9));

  localparam logic [ANGLE_W-1:0] ANGLE_0    = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] ANGLE_90   = ANGLE_W'(90 * 256);
  localparam logic [ANGLE_W-1:0] ANGLE_180  = ANGLE_W'(180 * 256);
  localparam logic [ANGLE_W-1:0] ANGLE_270  = ANGLE_W'(270 * 256);
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(360 * 256);

  // round(atan(2^-i) * 180/pi * 2^16)
  localparam logic [ATAN_W-1:0] ATAN_TAB [TAB_LEN] = '{
    ATAN_W'(2949120), ATAN_W'(1740967), ATAN_W'(919879), ATAN_W'(466945),
    ATAN_W'(234379),  ATAN_W'(117304),  ATAN_W'(58666),  ATAN_W'(29335),
    ATAN_W'(14668),   ATAN_W'(7334),    ATAN_W'(3667),   ATAN_W'(1833),
    ATAN_W'(917),     ATAN_W'(458),     ATAN_W'(229),    ATAN_W'(115),
    ATAN_W'(57),      ATAN_W'(29),      ATAN_W'(14),     ATAN_W'(7),
    ATAN_W'(4),       ATAN_W'(2),       ATAN_W'(1),      ATAN_W'(0),
    ATAN_W'(0),       ATAN_W'(0),       ATAN_W'(0),      ATAN_W'(0),
    ATAN_W'(0),       ATAN_W'(0),       ATAN_W'(0),      ATAN_W'(0)
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef enum logic [1:0] {
    DIR_POS_X = 2'd0,
    DIR_POS_Y = 2'd1,
    DIR_NEG_X = 2'd2,
    DIR_NEG_Y = 2'd3
  } dir_e;

  typedef struct packed {
    logic  valid;
    logic  origin;
    logic  axis;
    quad_e quad;
    dir_e  dir;
  } ctl_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [ANGLE_W-1:0]  angle;
    quad_e               quad;
    logic                origin;
    logic                axis;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ctp_prep.sv */
// Front end: classification, absolute values and sum of squares, three stages.
// Depends on ctp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctp_prep import ctp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  output ctl_t                       ctl_o,
  output logic [COORD_BITS-1:0]      ax_o,
  output logic [COORD_BITS-1:0]      ay_o,
  output logic [SQW-1:0]             sum_o
);

  ctl_t                  ctl_a_d, ctl_a_q, ctl_b_q, ctl_c_q;
  logic [COORD_BITS-1:0] ax_a_d, ay_a_d, ax_a_q, ay_a_q, ax_b_q, ay_b_q, ax_c_q, ay_c_q;
  logic [SQW-1:0]        sqx_b_q, sqy_b_q, sum_c_q;
  logic                  x_zero, y_zero, x_neg, y_neg;

  always_comb begin
    x_zero = (x_i == '0);
    y_zero = (y_i == '0);
    x_neg  = x_i[COORD_BITS-1];
    y_neg  = y_i[COORD_BITS-1];
    ax_a_d = x_neg ? (~x_i + COORD_BITS'(1)) : x_i;
    ay_a_d = y_neg ? (~y_i + COORD_BITS'(1)) : y_i;

    ctl_a_d.valid  = valid_i;
    ctl_a_d.origin = x_zero && y_zero;
    ctl_a_d.axis   = x_zero ^ y_zero;
    if (y_zero) begin
      ctl_a_d.dir = x_neg ? DIR_NEG_X : DIR_POS_X;
    end else begin
      ctl_a_d.dir = y_neg ? DIR_NEG_Y : DIR_POS_Y;
    end
    if (x_zero || y_zero) begin
      ctl_a_d.quad = QUAD_I;
    end else if (!x_neg && !y_neg) begin
      ctl_a_d.quad = QUAD_I;
    end else if (x_neg && !y_neg) begin
      ctl_a_d.quad = QUAD_II;
    end else if (x_neg) begin
      ctl_a_d.quad = QUAD_III;
    end else begin
      ctl_a_d.quad = QUAD_IV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_a_q  <= ax_a_d;
      ay_a_q  <= ay_a_d;
      ax_b_q  <= ax_a_q;
      ay_b_q  <= ay_a_q;
      sqx_b_q <= SQW'(ax_a_q) * SQW'(ax_a_q);
      sqy_b_q <= SQW'(ay_a_q) * SQW'(ay_a_q);
      ax_c_q  <= ax_b_q;
      ay_c_q  <= ay_b_q;
      sum_c_q <= sqx_b_q + sqy_b_q;
    end
  end

  assign ctl_o = ctl_c_q;
  assign ax_o  = ax_c_q;
  assign ay_o  = ay_c_q;
  assign sum_o = sum_c_q;

endmodule

`default_nettype wire

/* hw/rtl/ctp_iter.sv */
// Iteration pipeline: one vectoring rotation and one square root digit a stage.
// Depends on ctp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctp_iter import ctp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire ctl_t                  ctl_i,
  input  wire logic [COORD_BITS-1:0] ax_i,
  input  wire logic [COORD_BITS-1:0] ay_i,
  input  wire logic [SQW-1:0]        sum_i,
  output ctl_t                       ctl_o,
  output logic signed [ZW-1:0]       z_o,
  output logic [COORD_BITS-1:0]      root_o,
  output logic [RMW-1:0]             rem_o
);

  ctl_t                  ctl_q  [NSTG];
  logic signed [CW-1:0]  cx_q   [NSTG];
  logic signed [CW-1:0]  cy_q   [NSTG];
  logic signed [ZW-1:0]  z_q    [NSTG];
  logic [SQW-1:0]        n_q    [NSTG];
  logic [COORD_BITS-1:0] root_q [NSTG];
  logic [RMW-1:0]        rem_q  [NSTG];

  logic signed [CW-1:0] cx_init, cy_init;

  assign cx_init = $signed(CW'({ax_i, {GUARD_BITS{1'b0}}}));
  assign cy_init = $signed(CW'({ay_i, {GUARD_BITS{1'b0}}}));

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    ctl_t                  ctl_p;
    logic signed [CW-1:0]  cx_p, cy_p, cx_d, cy_d;
    logic signed [ZW-1:0]  z_p, z_d;
    logic [SQW-1:0]        n_p, n_d;
    logic [COORD_BITS-1:0] root_p, root_d;
    logic [RMW-1:0]        rem_p, rem_d;

    if (k == 0) begin : g_first
      assign ctl_p  = ctl_i;
      assign cx_p   = cx_init;
      assign cy_p   = cy_init;
      assign z_p    = '0;
      assign n_p    = sum_i;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_next
      assign ctl_p  = ctl_q[k-1];
      assign cx_p   = cx_q[k-1];
      assign cy_p   = cy_q[k-1];
      assign z_p    = z_q[k-1];
      assign n_p    = n_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
    end

    if (k < ROTATION_STEPS) begin : g_rot
      logic signed [ZW-1:0] step_z;
      assign step_z = $signed({1'b0, ATAN_TAB[k]});
      // Rotate toward the x axis; the sign of y picks the direction.
      always_comb begin
        if (!cy_p[CW-1]) begin
          cx_d = cx_p + (cy_p >>> k);
          cy_d = cy_p - (cx_p >>> k);
          z_d  = z_p + step_z;
        end else begin
          cx_d = cx_p - (cy_p >>> k);
          cy_d = cy_p + (cx_p >>> k);
          z_d  = z_p - step_z;
        end
      end
    end else begin : g_rot_idle
      assign cx_d = cx_p;
      assign cy_d = cy_p;
      assign z_d  = z_p;
    end

    if (k < COORD_BITS) begin : g_root
      logic [RMW-1:0] rem_cat, trial;
      // Restoring square root: two radicand bits enter per digit.
      always_comb begin
        rem_cat = {rem_p[RMW-3:0], n_p[SQW-1 -: 2]};
        trial   = {root_p, 2'b01};
        n_d     = n_p << 2;
        if (rem_cat >= trial) begin
          rem_d  = rem_cat - trial;
          root_d = {root_p[COORD_BITS-2:0], 1'b1};
        end else begin
          rem_d  = rem_cat;
          root_d = {root_p[COORD_BITS-2:0], 1'b0};
        end
      end
    end else begin : g_root_idle
      assign n_d    = n_p;
      assign rem_d  = rem_p;
      assign root_d = root_p;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[k]   <= cx_d;
        cy_q[k]   <= cy_d;
        z_q[k]    <= z_d;
        n_q[k]    <= n_d;
        root_q[k] <= root_d;
        rem_q[k]  <= rem_d;
      end
    end
  end

  assign ctl_o  = ctl_q[NSTG-1];
  assign z_o    = z_q[NSTG-1];
  assign root_o = root_q[NSTG-1];
  assign rem_o  = rem_q[NSTG-1];

endmodule

`default_nettype wire

/* hw/rtl/ctp_out.sv */
// Back end: clamp and root rounding, quadrant fold, output register and skid.
// Depends on ctp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctp_out import ctp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctl_t                  ctl_i,
  input  wire logic signed [ZW-1:0]  z_i,
  input  wire logic [COORD_BITS-1:0] root_i,
  input  wire logic [RMW-1:0]        rem_i,
  input  wire logic                  out_ready_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  output res_t                       res_o
);

  ctl_t                ctl_f_q;
  logic [TW-1:0]       t_d, t_f_q;
  logic [RADIUS_W-1:0] radius_d, radius_f_q;
  logic                round_up;
  logic [RND_W-1:0]    rnd;
  logic [RND_EXT_W-1:0] rnd_ext;

  logic [FW-1:0]       t_ext, full, biased;
  logic [ANGLE_W-1:0]  angle_fold;
  res_t                res_d;

  logic out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic load_out, load_skid, from_skid;
  res_t out_d, out_q, skid_q;

  assign en_o = !skid_valid_q;

  // Clamp the accumulated angle and round the root to nearest.
  always_comb begin
    if (z_i[ZW-1]) begin
      t_d = '0;
    end else if (z_i > $signed(DEG_90)) begin
      t_d = DEG_90[TW-1:0];
    end else begin
      t_d = z_i[TW-1:0];
    end
    round_up = (rem_i > RMW'(root_i));
    rnd      = RND_W'(root_i) + RND_W'(round_up);
    rnd_ext  = RND_EXT_W'(rnd);
    radius_d = (rnd_ext > RND_EXT_W'(RADIUS_MAX)) ? RADIUS_MAX : rnd_ext[RADIUS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_f_q <= '0;
    end else if (en_o) begin
      ctl_f_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      t_f_q      <= t_d;
      radius_f_q <= radius_d;
    end
  end

  // Fold the first-quadrant angle into the full circle.
  always_comb begin
    t_ext = FW'(t_f_q);
    case (ctl_f_q.quad)
      QUAD_I:   full = t_ext;
      QUAD_II:  full = DEG_180 - t_ext;
      QUAD_III: full = DEG_180 + t_ext;
      QUAD_IV:  full = DEG_360 - t_ext;
      default:  full = t_ext;
    endcase
    biased     = full + ROUND_BIAS;
    angle_fold = biased[FW-1 -: ANGLE_W];
    if (angle_fold >= ANGLE_FULL) begin
      angle_fold = ANGLE_0;
    end

    res_d.radius = radius_f_q;
    res_d.quad   = ctl_f_q.quad;
    res_d.origin = ctl_f_q.origin;
    res_d.axis   = ctl_f_q.axis;
    if (ctl_f_q.origin) begin
      res_d.angle = ANGLE_0;
    end else if (ctl_f_q.axis) begin
      case (ctl_f_q.dir)
        DIR_POS_X: res_d.angle = ANGLE_0;
        DIR_POS_Y: res_d.angle = ANGLE_90;
        DIR_NEG_X: res_d.angle = ANGLE_180;
        DIR_NEG_Y: res_d.angle = ANGLE_270;
        default:   res_d.angle = ANGLE_0;
      endcase
    end else begin
      res_d.angle = angle_fold;
    end
  end

  // Output register with a one-entry skid behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    from_skid    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        from_skid    = 1'b1;
        load_out     = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = ctl_f_q.valid;
        load_out    = 1'b1;
      end
    end else if (!out_valid_q) begin
      out_valid_d = ctl_f_q.valid;
      load_out    = 1'b1;
    end else if (ctl_f_q.valid && en_o) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
    out_d = from_skid ? skid_q : res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
    if (load_skid) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

/* hw/rtl/cartesian_to_polar_quadrant.sv */
// Cartesian to polar converter with quadrant and axis classification.
// Input channel (x_coord_i, y_coord_i) with in_valid_i / in_ready_o carries one
// signed point per transfer; output channel with out_valid_o / out_ready_i
// carries one result per point: rounded radius, angle in degrees times 256,
// quadrant and the origin and on-axis flags.
// The point first passes three front-end stages (sign and axis decode, squares,
// sum of squares), then one stage per rotation step of the vectoring unit, with
// one square root digit resolved alongside in each of those stages, then a
// stage that clamps the angle and rounds the root, and the output register.
// A result shows on out_valid_o once its point has passed the three front-end
// stages, the NSTG iteration stages, the clamp stage and the output register;
// NSTG is the larger of the rotation step count and the coordinate width, which
// sets the depth of the iteration pipeline.
// Throughput is one transfer per cycle while the receiver takes results.
// Reset clears all valid bits, so the pipeline comes up empty and in_ready_o
// is high. When the receiver stalls, a result waits in the output register
// and the next one lands in a skid entry; only with the skid entry occupied
// does the whole pipeline hold, and in_ready_o stays low until the cycle after
// the next output transfer.
`timescale 1ns / 1ps
`default_nettype none
`include "cartesian_to_polar_quadrant_defines.svh"

module cartesian_to_polar_quadrant import ctp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COORD_BITS-1:0] x_coord_i,
  input  wire logic [COORD_BITS-1:0] y_coord_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [RADIUS_W-1:0]        radius_o,
  output logic [ANGLE_W-1:0]         angle_deg_o,
  output logic [1:0]                 quadrant_o,
  output logic                       at_origin_o,
  output logic                       on_axis_o
);

  // Pipeline advance: every stage moves together unless the skid is full.
  logic en;

  ctl_t                  prep_ctl, iter_ctl;
  logic [COORD_BITS-1:0] prep_ax, prep_ay;
  logic [SQW-1:0]        prep_sum;
  logic signed [ZW-1:0]  iter_z;
  logic [COORD_BITS-1:0] iter_root;
  logic [RMW-1:0]        iter_rem;
  res_t                  res;

  assign in_ready_o = en;

  ctp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (x_coord_i),
    .y_i     (y_coord_i),
    .ctl_o   (prep_ctl),
    .ax_o    (prep_ax),
    .ay_o    (prep_ay),
    .sum_o   (prep_sum)
  );

  ctp_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (prep_ctl),
    .ax_i   (prep_ax),
    .ay_i   (prep_ay),
    .sum_i  (prep_sum),
    .ctl_o  (iter_ctl),
    .z_o    (iter_z),
    .root_o (iter_root),
    .rem_o  (iter_rem)
  );

  ctp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (iter_ctl),
    .z_i         (iter_z),
    .root_i      (iter_root),
    .rem_i       (iter_rem),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign radius_o    = res.radius;
  assign angle_deg_o = res.angle;
  assign quadrant_o  = res.quad;
  assign at_origin_o = res.origin;
  assign on_axis_o   = res.axis;

  // The origin and an axis point are exclusive cases.
  `CTP_ASSERT(a_flags_exclusive, clk_i, rst_ni, out_valid_o |-> !(at_origin_o && on_axis_o), "origin and axis flags both set")
  // The origin gives a zero radius and a zero angle.
  `CTP_ASSERT(a_origin_zero, clk_i, rst_ni, (out_valid_o && at_origin_o) |-> (radius_o == '0 && angle_deg_o == ANGLE_0), "origin result not zero")
  // An axis point lands exactly on a quarter turn in the first quadrant code.
  `CTP_ASSERT(a_axis_angle, clk_i, rst_ni, (out_valid_o && on_axis_o) |-> ((angle_deg_o == ANGLE_0 || angle_deg_o == ANGLE_90 || angle_deg_o == ANGLE_180 || angle_deg_o == ANGLE_270) && quadrant_o == QUAD_I), "axis angle not a quarter turn")
  // The input side only stalls while a result is waiting at the output.
  `CTP_ASSERT(a_stall_has_output, clk_i, rst_ni, !in_ready_o |-> out_valid_o, "input stalled with no result pending")
  // A full skid stays full until the receiver takes a result.
  `CTP_ASSERT_NEXT(a_skid_holds, clk_i, rst_ni, (!in_ready_o && !out_ready_i), !in_ready_o, "skid drained without an output transfer")

endmodule

`default_nettype wire

/* tb/tb_cartesian_to_polar_quadrant.sv */
// Self-checking testbench for the cartesian to polar converter.
// Depends on ctp_pkg for the widths and quadrant codes and on the cartesian_to_polar_quadrant RTL;
// a built-in predictor supplies the radius, angle and flags expected for each point.
`timescale 1ns / 1ps

module tb_cartesian_to_polar_quadrant;
  import ctp_pkg::*;

  // Run control.  The limit is far above the slowest legal run: every point
  // followed by a long sender gap and every result by a long receiver stall.
  localparam int RUN_LIMIT     = 400000;
  localparam int RANDOM_POINTS = 1100;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 60;
  localparam int MAX_REPORTS   = 10;

  // Angle constants in degrees times 2^16 (rotation) and times 2^8 (output).
  localparam longint Q16_90  = 64'sd90 <<< 16;
  localparam longint Q16_180 = 64'sd180 <<< 16;
  localparam longint Q16_360 = 64'sd360 <<< 16;
  localparam longint Q8_90   = 64'sd90 * 256;
  localparam longint Q8_180  = 64'sd180 * 256;
  localparam longint Q8_270  = 64'sd270 * 256;
  localparam longint Q8_360  = 64'sd360 * 256;

  // Arctangent of 2^-i in degrees times 2^16, rounded to nearest.
  localparam longint ARCTAN_Q16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  // A point waiting to be offered.  The gap is the number of idle cycles the
  // sender inserts after its transfer; a point marked to drain is held back
  // until every result already in flight has come out.
  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int                    gap;
    bit                    drain;
  } point_t;

  // The result expected for one point, with the point kept for messages.
  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [RADIUS_W-1:0]   radius;
    logic [ANGLE_W-1:0]    angle;
    quad_e                 quad;
    logic                  origin;
    logic                  axis;
  } polar_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [COORD_BITS-1:0] x_drv     = '0;
  logic [COORD_BITS-1:0] y_drv     = '0;
  logic                  out_ready = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [RADIUS_W-1:0]   radius_o;
  logic [ANGLE_W-1:0]    angle_deg_o;
  logic [1:0]            quadrant_o;
  logic                  at_origin_o;
  logic                  on_axis_o;

  point_t pending_points [$];
  polar_t expected_polar [$];

  // Counters.  Each one is written by a single process.  The ones polled by another
  // process during the run use nonblocking assignments, so those reads are race-free.
  int accepted_cnt = 0;
  int received_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int gap_left     = 0;
  int gap_after    = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int origin_seen  = 0;
  int axis_seen    = 0;
  int quad_seen [4] = '{0, 0, 0, 0};

  cartesian_to_polar_quadrant u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .x_coord_i   (x_drv),
    .y_coord_i   (y_drv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .radius_o    (radius_o),
    .angle_deg_o (angle_deg_o),
    .quadrant_o  (quadrant_o),
    .at_origin_o (at_origin_o),
    .on_axis_o   (on_axis_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicts the converter's result for one point.  The radius is an exact
  // integer square root rounded to nearest.  The angle comes from a vectoring
  // rotation of the absolute values, clamped to the first quadrant, then
  // folded by sign and rounded half up to degrees times 256.
  function automatic polar_t polar_of(logic [COORD_BITS-1:0] xr, logic [COORD_BITS-1:0] yr);
    polar_t res;
    longint xs, ys, ax, ay, sq, root, trial, cx, cy, dx, dy, z, full, ang;
    int     b, i;
    xs = longint'($signed(xr));
    ys = longint'($signed(yr));
    ax = (xs < 0) ? -xs : xs;
    ay = (ys < 0) ? -ys : ys;
    sq = ax * ax + ay * ay;

    root = 0;
    for (b = 16; b >= 0; b--) begin
      trial = root + (64'sd1 <<< b);
      if (trial * trial <= sq) root = trial;
    end
    // Round up when the square lies past the midpoint to the next root.
    if (sq - root * root > root) root = root + 1;
    if (root > 65535) root = 65535;

    res.x      = xr;
    res.y      = yr;
    res.radius = RADIUS_W'(root);
    res.quad   = QUAD_I;
    res.origin = 1'b0;
    res.axis   = 1'b0;
    ang = 0;

    if (xs == 0 && ys == 0) begin
      res.origin = 1'b1;
    end else if (ys == 0) begin
      res.axis = 1'b1;
      ang = (xs > 0) ? 0 : Q8_180;
    end else if (xs == 0) begin
      res.axis = 1'b1;
      ang = (ys > 0) ? Q8_90 : Q8_270;
    end else begin
      cx = ax <<< 16;
      cy = ay <<< 16;
      z = 0;
      for (i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ARCTAN_Q16[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ARCTAN_Q16[i];
        end
      end
      if (z < 0) z = 0;
      if (z > Q16_90) z = Q16_90;

      if (xs > 0 && ys > 0) begin
        res.quad = QUAD_I;
        full = z;
      end else if (xs < 0 && ys > 0) begin
        res.quad = QUAD_II;
        full = Q16_180 - z;
      end else if (xs < 0) begin
        res.quad = QUAD_III;
        full = Q16_180 + z;
      end else begin
        res.quad = QUAD_IV;
        full = Q16_360 - z;
      end
      ang = (full + 128) >>> 8;
      // A fourth-quadrant angle that rounds up to a full turn wraps to zero.
      if (ang >= Q8_360) ang = 0;
    end
    res.angle = ANGLE_W'(ang);
    return res;
  endfunction

  // Idle cycles after a transfer: mostly none or a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return 16'shFFFF;
      3: return 16'sh0000;
      4: return 16'sh0001;
      default: return 16'sh7FFF;
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] signed_mag(int mag);
    return ($urandom_range(0, 1) == 1) ? COORD_BITS'(-mag) : COORD_BITS'(mag);
  endfunction

  task automatic add_point(int xv, int yv, int gap, bit drain);
    point_t p;
    p.x     = COORD_BITS'(xv);
    p.y     = COORD_BITS'(yv);
    p.gap   = gap;
    p.drain = drain;
    pending_points.push_back(p);
  endtask

  // Random point from a mix of shapes: full range, tiny values that land on
  // the axes and the origin, axis points, extremes, near-diagonal points and
  // small magnitudes with random signs.
  task automatic add_random_point(int gap, bit drain);
    int xv, yv, m, r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      xv = $urandom_range(0, 65535);
      yv = $urandom_range(0, 65535);
    end else if (r < 55) begin
      xv = int'($urandom_range(0, 16)) - 8;
      yv = int'($urandom_range(0, 16)) - 8;
    end else if (r < 65) begin
      if ($urandom_range(0, 1) == 1) begin
        xv = $urandom_range(0, 65535);
        yv = 0;
      end else begin
        xv = 0;
        yv = $urandom_range(0, 65535);
      end
    end else if (r < 75) begin
      xv = pick_extreme();
      yv = pick_extreme();
    end else if (r < 85) begin
      m  = $urandom_range(1, 32000);
      xv = signed_mag(m);
      yv = signed_mag(m + int'($urandom_range(0, 8)) - 4);
    end else begin
      xv = signed_mag($urandom_range(0, 255));
      yv = signed_mag($urandom_range(0, 255));
    end
    add_point(xv, yv, gap, drain);
  endtask

  // Driver.  A point is offered until its transfer, then the sender waits
  // out the gap that came with it and loads the next one.  Valid stays high
  // across back-to-back transfers, so it gets one assignment per edge.
  always @(posedge clk_i or negedge rst_ni) begin
    bit     v_valid;
    int     v_gap;
    int     acc_now;
    point_t p;
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      x_drv        <= '0;
      y_drv        <= '0;
      gap_left     <= 0;
      gap_after    <= 0;
      accepted_cnt <= 0;
    end else begin
      v_valid = in_valid;
      v_gap   = gap_left;
      acc_now = accepted_cnt;
      if (in_valid && in_ready_o) begin
        expected_polar.push_back(polar_of(x_drv, y_drv));
        acc_now = acc_now + 1;
        v_valid = 1'b0;
        v_gap   = gap_after;
      end else if (!in_valid && v_gap > 0) begin
        v_gap = v_gap - 1;
      end
      if (!v_valid && v_gap == 0 && pending_points.size() > 0) begin
        // A drain point waits until every transferred point has its result.
        if (!pending_points[0].drain || acc_now == received_cnt) begin
          p = pending_points.pop_front();
          x_drv     <= p.x;
          y_drv     <= p.y;
          gap_after <= p.gap;
          v_valid   = 1'b1;
        end
      end
      in_valid     <= v_valid;
      gap_left     <= v_gap;
      accepted_cnt <= acc_now;
    end
  end

  // Monitor and receiver.  Each result transfer is checked against the
  // oldest expectation.  Ready follows its own pattern: random stalls, one
  // long hold-off while the sender streams, and a window with no stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    polar_t e;
    bit     r_ready;
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      received_cnt <= 0;
      stall_left   <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        received_cnt <= received_cnt + 1;
        if (expected_polar.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("[%0t] result with no point waiting: radius %0d angle %0d quad %0d",
                     $realtime, radius_o, angle_deg_o, quadrant_o);
          mismatch_cnt++;
        end else begin
          e = expected_polar.pop_front();
          if (radius_o !== e.radius || angle_deg_o !== e.angle || quadrant_o !== e.quad ||
              at_origin_o !== e.origin || on_axis_o !== e.axis) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("[%0t] point (%0d, %0d) mismatch", $realtime,
                       $signed(e.x), $signed(e.y));
              $display("  expected radius %0d angle %0d quad %0d origin %0b axis %0b",
                       e.radius, e.angle, e.quad, e.origin, e.axis);
              $display("  actual   radius %0d angle %0d quad %0d origin %0b axis %0b",
                       radius_o, angle_deg_o, quadrant_o, at_origin_o, on_axis_o);
            end
            mismatch_cnt++;
          end
          if (e.origin) origin_seen++;
          else if (e.axis) axis_seen++;
          else quad_seen[e.quad]++;
        end
      end

      r_ready = 1'b1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        r_ready = 1'b0;
      end else if (!hold_done && received_cnt >= 420) begin
        // The sender streams without gaps here, so the pipeline fills and
        // in_ready_o has to drop during this hold-off.
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        r_ready = 1'b0;
      end else if (received_cnt >= 800 && received_cnt < 900) begin
        r_ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        r_ready = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        r_ready = 1'b0;
      end
      out_ready <= r_ready;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_polar.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n, g;
    int leftover;

    // Directed points: the origin, both ends of both axes, unit steps on the
    // axes, the corners, unit diagonals in every quadrant, angles close to
    // the axes where the rotation clamps, and a fourth-quadrant point whose
    // angle rounds to a full turn and wraps to zero.
    add_point(0, 0, 0, 1'b0);
    add_point(32767, 0, 0, 1'b0);
    add_point(-32768, 0, 1, 1'b0);
    add_point(0, 32767, 0, 1'b0);
    add_point(0, -32768, 2, 1'b0);
    add_point(1, 0, 0, 1'b0);
    add_point(-1, 0, 0, 1'b0);
    add_point(0, 1, 0, 1'b0);
    add_point(0, -1, 0, 1'b0);
    add_point(32767, 32767, 0, 1'b0);
    add_point(-32768, 32767, 3, 1'b0);
    add_point(-32768, -32768, 0, 1'b0);
    add_point(32767, -32768, 0, 1'b0);
    add_point(1, 1, 0, 1'b0);
    add_point(-1, 1, 0, 1'b0);
    add_point(-1, -1, 0, 1'b0);
    add_point(1, -1, 0, 1'b0);
    add_point(1, 32767, 0, 1'b0);
    add_point(32767, 1, 0, 1'b0);
    add_point(-32768, 1, 0, 1'b0);
    add_point(-32768, -1, 0, 1'b0);
    add_point(32767, -1, 0, 1'b0);
    add_point(-1, -32768, 0, 1'b0);
    add_point(3, 4, 0, 1'b0);

    // Random part.  The first random point and one later on wait for the
    // pipeline to drain.  A long stretch around the receiver's hold-off and
    // one in its no-stall window go without sender gaps.
    for (n = 0; n < RANDOM_POINTS; n++) begin
      if ((n >= 380 && n < 720) || (n >= 780 && n < 900)) g = 0;
      else g = pick_gap();
      add_random_point(g, (n == 0 || n == 1000));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every point has gone in and every result has come out.
    // Checked at the falling edge, once the rising-edge updates have settled.
    forever begin
      @(negedge clk_i);
      if (pending_points.size() == 0 && !in_valid && accepted_cnt == received_cnt) break;
    end
    // Let the pipeline run on so that any stray result would still show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    leftover = expected_polar.size();
    if (leftover != 0)
      $display("%0d expected results never arrived", leftover);

    $display("converted %0d points in %0d cycles: %0d origin, %0d on an axis",
             received_cnt, cycle_cnt, origin_seen, axis_seen);
    $display("quadrants I..IV: %0d %0d %0d %0d; %0d mismatches",
             quad_seen[0], quad_seen[1], quad_seen[2], quad_seen[3], mismatch_cnt);
    if (mismatch_cnt == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ctp_pkg.sv
hw/rtl/ctp_prep.sv
hw/rtl/ctp_iter.sv
hw/rtl/ctp_out.sv
hw/rtl/cartesian_to_polar_quadrant.sv
tb/tb_cartesian_to_polar_quadrant.sv
